[src/swl_pkg.sv]
// Package for the string wave leapfrog solver: widths, command codes, states
// and the structs passed between the sequencer and the point update pipeline.
// Depends on nothing; every other file imports it.
`default_nettype none

package swl_pkg;

  localparam int GRID_POINTS = 64;
  localparam int MIN_GRID    = 3;
  localparam int IDX_W       = $clog2(GRID_POINTS);
  localparam int GRID_W      = 7;
  localparam int NCLOG       = $clog2(GRID_POINTS + 1);
  localparam int N_W         = (NCLOG > GRID_W) ? NCLOG : GRID_W;
  localparam int CNT_W       = N_W + 1;

  localparam int CMD_W       = 2;
  localparam int PIDX_W      = 6;
  localparam int VAL_W       = 24;
  localparam int STEP_W      = 16;
  localparam int LAM_W       = 17;
  localparam int DIFF_W      = VAL_W + 2;
  localparam int ACC_W       = LAM_W + 1 + DIFF_W;

  localparam int ONE_Q16     = 65536;
  localparam int VAL_MAX     = 8388607;
  localparam int VAL_MIN     = -8388608;
  localparam int SH_FIRST    = 17;
  localparam int SH_LEAP     = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SOLVE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_GRID_USED = 1'b0,
    CFG_COURANT   = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SWEEP
  } st_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic [CNT_W-1:0] j;
  } sweep_tag_t;

  typedef struct packed {
    logic             now_we;
    logic             before_we;
    logic [IDX_W-1:0] addr;
    logic [VAL_W-1:0] now_data;
    logic [VAL_W-1:0] before_data;
  } lvl_wr_t;

endpackage

`default_nettype wire

[src/swl_update.sv]
// Point update pipeline: sliding window over the latest level, one shared
// multiplier, rounding and saturation, and the write-back of one point a cycle.
// Depends on swl_pkg.
`default_nettype none

module swl_update
  import swl_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire sweep_tag_t              tag,
  input  wire logic [CNT_W-1:0]        n_pts,
  input  wire logic [LAM_W-1:0]        lam,
  input  wire logic signed [VAL_W-1:0] rd_now,
  input  wire logic signed [VAL_W-1:0] rd_before,
  output lvl_wr_t                      wr
);

  logic signed [VAL_W-1:0]  left_r, cur_r, prev_r, right_m;
  logic [CNT_W-1:0]         i_s1;
  logic                     s1_act;
  logic signed [DIFF_W-1:0] diff_s1;

  logic                     s2_vld_r, s2_first_r, s2_end_r, s2_out_r;
  logic [IDX_W-1:0]         s2_idx_r;
  logic signed [DIFF_W-1:0] s2_diff_r;
  logic signed [VAL_W-1:0]  s2_cur_r, s2_prev_r;
  logic signed [LAM_W:0]    lam_s;
  logic signed [ACC_W-1:0]  prod_s2, base_s2, cur_sh, prev_sh;

  logic                     s3_vld_r, s3_first_r, s3_end_r, s3_out_r;
  logic [IDX_W-1:0]         s3_idx_r;
  logic signed [ACC_W-1:0]  s3_prod_r, s3_base_r;
  logic signed [VAL_W-1:0]  s3_cur_r, s3_prev_r;
  logic signed [ACC_W-1:0]  acc, rnd;
  logic signed [VAL_W-1:0]  sat;

  // The end points are read as zero; the fixed ends are written as zero in the first step.
  always_comb begin
    i_s1    = tag.j - CNT_W'(1);
    s1_act  = tag.valid && (tag.j != '0);
    right_m = ((tag.j == '0) || (tag.j == n_pts - CNT_W'(1))) ? '0 : rd_now;
    diff_s1 = DIFF_W'(left_r) + DIFF_W'(right_m) - (DIFF_W'(cur_r) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (tag.valid) begin
      left_r <= cur_r;
      cur_r  <= right_m;
      prev_r <= rd_before;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_act;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_first_r <= tag.first;
    s2_end_r   <= (i_s1 == '0) || (i_s1 == n_pts - CNT_W'(1));
    s2_out_r   <= (i_s1 >= n_pts);
    s2_idx_r   <= i_s1[IDX_W-1:0];
    s2_diff_r  <= diff_s1;
    s2_cur_r   <= cur_r;
    s2_prev_r  <= prev_r;
  end

  // The update is written as 2u*2^16 + L*(left + right - 2u), less u_prev*2^16 when leaping.
  always_comb begin
    lam_s   = $signed({1'b0, lam});
    prod_s2 = lam_s * s2_diff_r;
    cur_sh  = ACC_W'(s2_cur_r) <<< SH_FIRST;
    prev_sh = ACC_W'(s2_prev_r) <<< SH_LEAP;
    base_s2 = s2_first_r ? cur_sh : (cur_sh - prev_sh);
  end

  always_ff @(posedge clk) begin
    s3_first_r <= s2_first_r;
    s3_end_r   <= s2_end_r;
    s3_out_r   <= s2_out_r;
    s3_idx_r   <= s2_idx_r;
    s3_prod_r  <= prod_s2;
    s3_base_r  <= base_s2;
    s3_cur_r   <= s2_cur_r;
    s3_prev_r  <= s2_prev_r;
  end

  always_comb begin
    acc = s3_prod_r + s3_base_r;
    if (s3_first_r) begin
      rnd = (acc + (ACC_W'(1) <<< (SH_FIRST - 1))) >>> SH_FIRST;
    end else begin
      rnd = (acc + (ACC_W'(1) <<< (SH_LEAP - 1))) >>> SH_LEAP;
    end
    if (rnd > ACC_W'(VAL_MAX)) begin
      sat = VAL_W'(VAL_MAX);
    end else if (rnd < ACC_W'(VAL_MIN)) begin
      sat = VAL_W'(VAL_MIN);
    end else begin
      sat = rnd[VAL_W-1:0];
    end
  end

  // Points beyond the grid in use trade places between the two levels, so they
  // keep their contents when the level roles swap.
  always_comb begin
    wr.addr        = s3_idx_r;
    wr.now_we      = 1'b0;
    wr.before_we   = 1'b0;
    wr.now_data    = '0;
    wr.before_data = '0;
    if (s3_vld_r) begin
      priority if (s3_out_r) begin
        wr.now_we      = 1'b1;
        wr.before_we   = 1'b1;
        wr.now_data    = s3_prev_r;
        wr.before_data = s3_cur_r;
      end else if (s3_end_r) begin
        wr.now_we      = s3_first_r;
        wr.before_we   = 1'b1;
      end else begin
        wr.before_we   = 1'b1;
        wr.before_data = sat;
      end
    end
  end

endmodule

`default_nettype wire

[src/string_wave_leapfrog_solver_top.sv]
// Load items never raise busy: a load result is registered in the cycle after
// start. A read passes through ST_READ, with busy high for one cycle, and its
// result is registered after it. A solve of k steps keeps busy high for k sweeps
// (one sweep of the shared update pipeline per step), and its result is valid
// in the cycle in which busy falls. After reset a clearing pass over every point
// zeroes both levels with busy high; configuration writes are taken at any time.
`default_nettype none

module string_wave_leapfrog_solver_top
  import swl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [CMD_W-1:0]         in_cmd,
  input  wire logic [PIDX_W-1:0]        in_point_index,
  input  wire logic signed [VAL_W-1:0]  in_displacement,
  input  wire logic [STEP_W-1:0]        in_step_count,
  output logic                          out_valid,
  output logic signed [VAL_W-1:0]       out_point_value,
  output logic                          out_status,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic                     cfg_index,
  input  wire logic [LAM_W-1:0]         cfg_data
);

  st_t                     state_r, state_nxt;
  logic [CNT_W-1:0]        p_r, p_nxt;
  logic [STEP_W-1:0]       steps_r, steps_nxt;
  logic                    first_r, first_nxt;
  logic                    sel_r, sel_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic                    out_status_r, out_status_nxt;

  logic [GRID_W-1:0]       grid_used_r;
  logic [LAM_W-1:0]        courant_r;
  logic [CNT_W-1:0]        gu, n_eff, idx_c;
  logic [LAM_W-1:0]        lam;
  logic                    in_range, end_pt;

  logic                    ld_we;
  logic signed [VAL_W-1:0] ld_data;

  logic signed [VAL_W-1:0] mem_a [GRID_POINTS];
  logic signed [VAL_W-1:0] mem_b [GRID_POINTS];
  logic signed [VAL_W-1:0] rd_a_r, rd_b_r, rd_now, rd_before;
  logic [IDX_W-1:0]        rd_addr;
  logic                    wa_we, wb_we;
  logic [IDX_W-1:0]        wa_addr, wb_addr;
  logic signed [VAL_W-1:0] wa_data, wb_data;

  sweep_tag_t              tag_r;
  lvl_wr_t                 wr;

  assign cfg_ready       = 1'b1;
  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_point_value = out_value_r;
  assign out_status      = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_used_r <= GRID_W'(64);
      courant_r   <= LAM_W'(32768);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRID_USED: grid_used_r <= cfg_data[GRID_W-1:0];
        CFG_COURANT:   courant_r   <= cfg_data;
      endcase
    end
  end

  always_comb begin
    gu = CNT_W'(grid_used_r);
    if (gu < CNT_W'(MIN_GRID)) begin
      n_eff = CNT_W'(MIN_GRID);
    end else if (gu > CNT_W'(GRID_POINTS)) begin
      n_eff = CNT_W'(GRID_POINTS);
    end else begin
      n_eff = gu;
    end
    lam      = (courant_r > LAM_W'(ONE_Q16)) ? LAM_W'(ONE_Q16) : courant_r;
    idx_c    = CNT_W'(in_point_index);
    in_range = (idx_c < n_eff);
    end_pt   = (idx_c == '0) || (idx_c == n_eff - CNT_W'(1));
  end

  always_comb begin
    state_nxt      = state_r;
    p_nxt          = p_r;
    steps_nxt      = steps_r;
    first_nxt      = first_r;
    sel_nxt        = sel_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = '0;
    out_status_nxt = 1'b0;
    ld_we          = 1'b0;
    ld_data        = '0;
    unique case (state_r)
      ST_CLEAR: begin
        if (p_r == CNT_W'(GRID_POINTS - 1)) begin
          p_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          p_nxt = p_r + CNT_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (cmd_t'(in_cmd))
            CMD_LOAD: begin
              out_valid_nxt = 1'b1;
              if (in_range) begin
                ld_we   = 1'b1;
                ld_data = end_pt ? '0 : in_displacement;
              end else begin
                out_status_nxt = 1'b1;
              end
            end
            CMD_READ: begin
              if (in_range) begin
                state_nxt = ST_READ;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = 1'b1;
              end
            end
            CMD_SOLVE: begin
              if (in_step_count == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_SWEEP;
                p_nxt     = '0;
                steps_nxt = in_step_count;
                first_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_now;
        state_nxt     = ST_IDLE;
      end
      ST_SWEEP: begin
        if (p_r == CNT_W'(GRID_POINTS + 3)) begin
          sel_nxt   = ~sel_r;
          p_nxt     = '0;
          first_nxt = 1'b0;
          if (steps_r == STEP_W'(1)) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            steps_nxt = steps_r - STEP_W'(1);
          end
        end else begin
          p_nxt = p_r + CNT_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      p_r         <= '0;
      steps_r     <= '0;
      first_r     <= 1'b0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
      tag_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      p_r         <= p_nxt;
      steps_r     <= steps_nxt;
      first_r     <= first_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
      tag_r.valid <= (state_r == ST_SWEEP) && (p_r <= CNT_W'(GRID_POINTS));
      tag_r.first <= first_r;
      tag_r.j     <= p_r;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // Bank A holds the latest level while sel_r is low, bank B while it is high.
  always_comb begin
    rd_addr   = (state_r == ST_SWEEP) ? p_r[IDX_W-1:0] : IDX_W'(in_point_index);
    rd_now    = sel_r ? rd_b_r : rd_a_r;
    rd_before = sel_r ? rd_a_r : rd_b_r;
    wa_we     = 1'b0;
    wb_we     = 1'b0;
    wa_addr   = wr.addr;
    wb_addr   = wr.addr;
    wa_data   = '0;
    wb_data   = '0;
    priority if (state_r == ST_CLEAR) begin
      wa_we   = 1'b1;
      wb_we   = 1'b1;
      wa_addr = p_r[IDX_W-1:0];
      wb_addr = p_r[IDX_W-1:0];
    end else if (ld_we) begin
      wa_we   = ~sel_r;
      wb_we   = sel_r;
      wa_addr = IDX_W'(in_point_index);
      wb_addr = IDX_W'(in_point_index);
      wa_data = ld_data;
      wb_data = ld_data;
    end else begin
      wa_we   = sel_r ? wr.before_we : wr.now_we;
      wb_we   = sel_r ? wr.now_we : wr.before_we;
      wa_data = sel_r ? $signed(wr.before_data) : $signed(wr.now_data);
      wb_data = sel_r ? $signed(wr.now_data) : $signed(wr.before_data);
    end
  end

  always_ff @(posedge clk) begin
    if (wa_we) begin
      mem_a[wa_addr] <= wa_data;
    end
    rd_a_r <= mem_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wb_we) begin
      mem_b[wb_addr] <= wb_data;
    end
    rd_b_r <= mem_b[rd_addr];
  end

  swl_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag       (tag_r),
    .n_pts     (n_eff),
    .lam       (lam),
    .rd_now    (rd_now),
    .rd_before (rd_before),
    .wr        (wr)
  );

endmodule

`default_nettype wire
